### hw/rtl/hpt_pkg.sv
// Shared types, widths and codes for the homogeneous point transform.
package hpt_pkg;

    localparam int COORD_W   = 32;
    localparam int CFG_W     = 64;
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 66;
    localparam int MAG_W     = 65;
    localparam int NORM_W    = 31;
    localparam int SQ_W      = 62;
    localparam int SUM_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int Q_W       = 33;
    localparam int BL_W      = 7;

    localparam int FRONT_LAT = 9;
    localparam int SQRT_LAT  = SUM_W / 2;
    localparam int DIV_LAT   = Q_W + 1;
    localparam int TOTAL_LAT = FRONT_LAT + SQRT_LAT + DIV_LAT + 1;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_DIR   = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_W_ZERO   = 2'd1;
    localparam logic [1:0] ST_LEN_ZERO = 2'd2;

    typedef struct packed {
        logic                      operation;
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
    } hpt_cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic [1:0]                status;
    } hpt_result_t;

    typedef struct packed {
        logic                    dir;
        logic [1:0]              status;
        logic [2:0]              neg;
        logic [2:0][MAG_W-1:0]   num;
        logic [MAG_W-1:0]        den;
    } hpt_side_t;

    typedef struct packed {
        logic       vld;
        logic [1:0] status;
        logic [2:0] neg;
    } hpt_tag_t;

endpackage

### hw/rtl/hpt_front.sv
// Front pipeline: matrix product, magnitudes, normalization and sum of squares.
module hpt_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_vld,
    input  hpt_pkg::hpt_cmd_t                               cmd,
    input  logic [hpt_pkg::NUM_CFG-1:0][hpt_pkg::CFG_W-1:0] coef,
    output logic                                            out_vld,
    output logic [hpt_pkg::SUM_W-1:0]                       out_sum,
    output hpt_pkg::hpt_side_t                              out_side
);
    import hpt_pkg::*;

    localparam int NGRP = (MAG_W + 7) / 8;
    localparam int GW   = NGRP * 8;

    logic [FRONT_LAT-1:0] vld_reg;

    hpt_cmd_t cmd_reg;

    logic signed [PROD_W-1:0] prod_reg [4][3];
    logic signed [PROD_W-1:0] prod_next [4][3];
    logic                     dir1_reg;

    logic signed [ACC_W-1:0] acc_reg [4];
    logic signed [ACC_W-1:0] acc_next [4];
    logic                    dir2_reg;

    logic [MAG_W-1:0] mag3_reg [4];
    logic [MAG_W-1:0] mag3_next [4];
    logic [3:0]       neg3_reg;
    logic             dir3_reg;
    logic             wz3_reg;

    logic [MAG_W-1:0] mag4_reg [4];
    logic [3:0]       neg4_reg;
    logic             dir4_reg;
    logic             wz4_reg;
    logic [NGRP-1:0]  nz4_reg;
    logic [NGRP-1:0]  nz4_next;
    logic [3:0]       lb4_reg [NGRP];
    logic [3:0]       lb4_next [NGRP];

    logic [MAG_W-1:0] mag5_reg [4];
    logic [3:0]       neg5_reg;
    logic             dir5_reg;
    logic             wz5_reg;
    logic [BL_W-1:0]  bl5_reg;
    logic [BL_W-1:0]  bl5_next;

    logic [NORM_W-1:0] s6_reg [3];
    logic [NORM_W-1:0] s6_next [3];
    hpt_side_t         side6_reg;
    hpt_side_t         side6_next;

    logic [SQ_W-1:0] sq7_reg [3];
    hpt_side_t       side7_reg;

    logic [SUM_W-1:0] sum8_reg;
    hpt_side_t        side8_reg;

    logic signed [COORD_W-1:0] cf [4][4];
    logic signed [COORD_W-1:0] vin [3];
    logic [GW-1:0]             orv;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                cf[r][c] = coef[2 * r + (c >> 1)][32 * (c & 1) +: 32];
            end
        end
    end

    assign vin[0] = cmd_reg.in_x;
    assign vin[1] = cmd_reg.in_y;
    assign vin[2] = cmd_reg.in_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_vld};
        end
    end

    // products of the three coordinate columns
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r][c] = cf[r][c] * vin[c];
            end
        end
    end

    // row sums; the fourth column is 1.0 in point mode, a plain shift
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            acc_next[r] = ACC_W'(prod_reg[r][0]) + ACC_W'(prod_reg[r][1])
                        + ACC_W'(prod_reg[r][2])
                        + (dir1_reg ? ACC_W'(0) : (ACC_W'(cf[r][3]) <<< FRAC_BITS));
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            mag3_next[r] = acc_reg[r][ACC_W-1] ? MAG_W'(-acc_reg[r]) : MAG_W'(acc_reg[r]);
        end
    end

    // per-byte leading one search over the OR of the three magnitudes
    assign orv = GW'(mag3_reg[0] | mag3_reg[1] | mag3_reg[2]);

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            nz4_next[g] = |orv[8 * g +: 8];
            lb4_next[g] = 4'd0;
            for (int b = 0; b < 8; b++)
            begin
                if (orv[8 * g + b])
                begin
                    lb4_next[g] = 4'(b + 1);
                end
            end
        end
    end

    always_comb
    begin
        bl5_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (nz4_reg[g])
            begin
                bl5_next = BL_W'(8 * g) + BL_W'(lb4_reg[g]);
            end
        end
    end

    // bring the largest magnitude into [2^30, 2^31)
    always_comb
    begin
        logic [MAG_W-1:0] shv;
        shv = '0;
        for (int r = 0; r < 3; r++)
        begin
            if (bl5_reg > BL_W'(NORM_W))
            begin
                shv = mag5_reg[r] >> (bl5_reg - BL_W'(NORM_W));
            end
            else
            begin
                shv = mag5_reg[r] << (BL_W'(NORM_W) - bl5_reg);
            end
            s6_next[r] = shv[NORM_W-1:0];
        end
        side6_next.dir = dir5_reg;
        if (dir5_reg == OP_DIR)
        begin
            side6_next.status = (bl5_reg == '0) ? ST_LEN_ZERO : ST_OK;
            side6_next.neg    = neg5_reg[2:0];
            for (int r = 0; r < 3; r++)
            begin
                side6_next.num[r] = MAG_W'(s6_next[r]);
            end
        end
        else
        begin
            side6_next.status = wz5_reg ? ST_W_ZERO : ST_OK;
            side6_next.neg    = neg5_reg[2:0] ^ {3{neg5_reg[3]}};
            for (int r = 0; r < 3; r++)
            begin
                side6_next.num[r] = mag5_reg[r];
            end
        end
        side6_next.den = mag5_reg[3];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd;

        prod_reg <= prod_next;
        dir1_reg <= cmd_reg.operation;

        acc_reg  <= acc_next;
        dir2_reg <= dir1_reg;

        mag3_reg <= mag3_next;
        for (int r = 0; r < 4; r++)
        begin
            neg3_reg[r] <= acc_reg[r][ACC_W-1];
        end
        dir3_reg <= dir2_reg;
        wz3_reg  <= (acc_reg[3] == '0);

        mag4_reg <= mag3_reg;
        neg4_reg <= neg3_reg;
        dir4_reg <= dir3_reg;
        wz4_reg  <= wz3_reg;
        nz4_reg  <= nz4_next;
        lb4_reg  <= lb4_next;

        mag5_reg <= mag4_reg;
        neg5_reg <= neg4_reg;
        dir5_reg <= dir4_reg;
        wz5_reg  <= wz4_reg;
        bl5_reg  <= bl5_next;

        s6_reg    <= s6_next;
        side6_reg <= side6_next;

        for (int r = 0; r < 3; r++)
        begin
            sq7_reg[r] <= SQ_W'(s6_reg[r]) * SQ_W'(s6_reg[r]);
        end
        side7_reg <= side6_reg;

        sum8_reg  <= SUM_W'(sq7_reg[0]) + SUM_W'(sq7_reg[1]) + SUM_W'(sq7_reg[2]);
        side8_reg <= side7_reg;
    end

    assign out_vld  = vld_reg[FRONT_LAT-1];
    assign out_sum  = sum8_reg;
    assign out_side = side8_reg;

endmodule

### hw/rtl/hpt_isqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
module hpt_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_vld,
    input  logic [hpt_pkg::SUM_W-1:0]   in_val,
    input  hpt_pkg::hpt_side_t          in_side,
    output logic                        out_vld,
    output logic [hpt_pkg::ROOT_W-1:0]  out_root,
    output hpt_pkg::hpt_side_t          out_side
);
    import hpt_pkg::*;

    logic              vld  [SQRT_LAT+1];
    logic [SUM_W-1:0]  rem  [SQRT_LAT+1];
    logic [SUM_W-1:0]  res  [SQRT_LAT+1];
    hpt_side_t         side [SQRT_LAT+1];

    assign vld[0]  = in_vld;
    assign rem[0]  = in_val;
    assign res[0]  = '0;
    assign side[0] = in_side;

    for (genvar k = 0; k < SQRT_LAT; k++)
    begin : g_stage
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
        logic [SUM_W-1:0] trial;
        logic             ge;

        assign trial = res[k] + BIT;
        assign ge    = (rem[k] >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld[k+1] <= 1'b0;
            end
            else
            begin
                vld[k+1] <= vld[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem[k+1]  <= ge ? rem[k] - trial : rem[k];
            res[k+1]  <= ge ? (res[k] >> 1) + BIT : res[k] >> 1;
            side[k+1] <= side[k];
        end
    end

    assign out_vld  = vld[SQRT_LAT];
    assign out_root = res[SQRT_LAT][ROOT_W-1:0];
    assign out_side = side[SQRT_LAT];

endmodule

### hw/rtl/hpt_div.sv
// Pipelined restoring divider: floor(num * 2^(F+1) / den) with overflow flag.
module hpt_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic [hpt_pkg::MAG_W-1:0]  num,
    input  logic [hpt_pkg::MAG_W-1:0]  den,
    output logic [hpt_pkg::Q_W-1:0]    quo,
    output logic                       ovf
);
    import hpt_pkg::*;

    localparam int SH = COORD_W - FRAC_BITS;
    localparam int XW = MAG_W + FRAC_BITS + 1;

    logic [MAG_W-1:0] rem_reg [Q_W+1];
    logic [MAG_W-1:0] den_reg [Q_W+1];
    logic [Q_W-1:0]   x_reg [Q_W+1];
    logic [Q_W-1:0]   q_reg [Q_W+1];
    logic             ovf_reg [Q_W+1];
    logic [XW-1:0]    xw;

    assign xw = {num, {(FRAC_BITS + 1){1'b0}}};

    // quotient that would need more than Q_W bits saturates anyway
    always_ff @(posedge clk)
    begin
        ovf_reg[0] <= ({{SH{1'b0}}, num} >= {den, {SH{1'b0}}});
        rem_reg[0] <= num >> SH;
        x_reg[0]   <= xw[Q_W-1:0];
        q_reg[0]   <= '0;
        den_reg[0] <= den;
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        localparam int BI = Q_W - 1 - k;
        logic [MAG_W:0] r2;
        logic [MAG_W:0] diff;
        logic           ge;

        assign r2   = {rem_reg[k], x_reg[k][BI]};
        assign diff = r2 - {1'b0, den_reg[k]};
        assign ge   = (r2 >= {1'b0, den_reg[k]});

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= ge ? diff[MAG_W-1:0] : r2[MAG_W-1:0];
            q_reg[k+1]   <= {q_reg[k][Q_W-2:0], ge};
            x_reg[k+1]   <= x_reg[k];
            den_reg[k+1] <= den_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
    end

    assign quo = q_reg[Q_W];
    assign ovf = ovf_reg[Q_W];

endmodule

### hw/rtl/homogeneous_point_transform.sv
// Top level of the homogeneous 4x4 point and direction transform.
//
// Takes one command per clock (busy never rises) and returns one result per
// command after the transfer on start, through the front stages (matrix
// product, magnitude, normalization and sum of squares), the square-root
// stages (one root bit per stage), the division stages (one quotient bit
// per stage, three lanes side by side) and one output register. Point
// commands ride through the square-root stages unchanged so that results leave
// in command order. The result is on the result port for a single cycle with
// done high and cannot be held back. Point mode divides x, y, z by w, rounding
// to nearest with ties away from zero; w of zero gives status 1 and zeros.
// Direction mode scales to unit length; an all-zero vector gives status 2 and
// zeros. All outputs saturate to the signed 32-bit range. The matrix lives in
// eight 64-bit registers, two Q16.16 coefficients each, reset to identity;
// write them only while no command is in flight.
module homogeneous_point_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  hpt_pkg::hpt_cmd_t                 cmd,
    output logic                              done,
    output hpt_pkg::hpt_result_t              result,
    input  logic                              cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hpt_pkg::CFG_W-1:0]         cfg_data
);
    import hpt_pkg::*;

    localparam logic [COORD_W-1:0] ONE_Q = COORD_W'(1) << FRAC_BITS;
    localparam logic [NUM_CFG-1:0][CFG_W-1:0] CFG_RESET = {
        {ONE_Q, 32'h0}, 64'h0,
        {32'h0, ONE_Q}, 64'h0,
        64'h0, {ONE_Q, 32'h0},
        64'h0, {32'h0, ONE_Q}
    };

    logic [NUM_CFG-1:0][CFG_W-1:0] cfg_reg;

    logic               front_vld;
    logic [SUM_W-1:0]   front_sum;
    hpt_side_t          front_side;

    logic               sq_vld;
    logic [ROOT_W-1:0]  sq_root;
    hpt_side_t          sq_side;

    logic [MAG_W-1:0]   den_sel;
    logic [Q_W-1:0]     quo [3];
    logic [2:0]         ovf;

    hpt_tag_t           tag_reg [DIV_LAT];
    hpt_tag_t           tag_in;

    logic signed [COORD_W-1:0] val [3];
    hpt_result_t        result_reg;
    logic               done_reg;

    // every cycle can take a transfer; the pipeline never stalls
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    hpt_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (start & ~busy),
        .cmd      (cmd),
        .coef     (cfg_reg),
        .out_vld  (front_vld),
        .out_sum  (front_sum),
        .out_side (front_side)
    );

    hpt_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (front_vld),
        .in_val   (front_sum),
        .in_side  (front_side),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    // direction commands divide by the vector length, points by w
    assign den_sel = (sq_side.dir == OP_DIR) ? MAG_W'(sq_root) : sq_side.den;

    for (genvar r = 0; r < 3; r++)
    begin : g_lane
        hpt_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .num (sq_side.num[r]),
            .den (den_sel),
            .quo (quo[r]),
            .ovf (ovf[r])
        );
    end

    // hold valid, status and signs alongside the divider lanes
    assign tag_in = '{vld: sq_vld, status: sq_side.status, neg: sq_side.neg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // round half away from zero: (Q + 1) / 2, then apply sign and saturate; error status gives zero
    always_comb
    begin
        logic [Q_W:0]   qsum;
        logic [Q_W-1:0] qr;
        qsum = '0;
        qr   = '0;
        for (int r = 0; r < 3; r++)
        begin
            qsum = (Q_W + 1)'(quo[r]) + (Q_W + 1)'(1);
            qr   = qsum[Q_W:1];
            if (tag_reg[DIV_LAT-1].status != ST_OK)
            begin
                val[r] = '0;
            end
            else if (ovf[r] || qr[Q_W-1] || qr[Q_W-2])
            begin
                val[r] = tag_reg[DIV_LAT-1].neg[r] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            else if (tag_reg[DIV_LAT-1].neg[r])
            begin
                val[r] = -$signed(qr[COORD_W-1:0]);
            end
            else
            begin
                val[r] = $signed(qr[COORD_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tag_reg[DIV_LAT-1].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.out_x  <= val[0];
        result_reg.out_y  <= val[1];
        result_reg.out_z  <= val[2];
        result_reg.status <= tag_reg[DIV_LAT-1].status;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### hw/rtl/hpt_checker.sv
// Port-level checker for the homogeneous point transform, with its bind.
module hpt_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  hpt_pkg::hpt_cmd_t     cmd,
    input  logic                  done,
    input  hpt_pkg::hpt_result_t  result
);
    import hpt_pkg::*;

    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##TOTAL_LAT done)
        else $error("transfer on start produced no result");

    a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, TOTAL_LAT))
        else $error("result without matching command");

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |->
            result.out_x == 0 && result.out_y == 0 && result.out_z == 0)
        else $error("nonzero outputs with error status");

    a_point_st: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(cmd.operation, TOTAL_LAT) == OP_POINT |->
            result.status != ST_LEN_ZERO)
        else $error("point command reported zero length");

    a_dir_st: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(cmd.operation, TOTAL_LAT) == OP_DIR |->
            result.status != ST_W_ZERO)
        else $error("direction command reported zero w");

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (.*);
